// File: rtl/core/pcmmix_pkg.sv
// Shared widths, mode codes and stage payload types for the PCM mixer pipeline.
package pcmmix_pkg;

    localparam int SAMPLE_W      = 16;
    localparam int FRAC_W        = 15;
    localparam int GAIN_FRAC_W   = 12;
    localparam int COEF_W        = 16;
    localparam int THRESH_W      = 15;
    localparam int KIND_W        = 2;
    localparam int CFG_ADDR_W    = 2;

    // Mixed sum of two samples, one bit of growth.
    localparam int SUM_W         = SAMPLE_W + 1;
    // First-stage products: sum squared, lin * sum, sample * gain.
    localparam int PROD_W        = 2 * SUM_W;
    // Square shifted down; the square is never negative and tops out at 2^(2*SUM_W-2).
    localparam int X2_W          = 2 * SUM_W - 1 - FRAC_W;
    localparam int CUBE_PROD_W   = X2_W + 1 + SUM_W;
    localparam int X3_W          = CUBE_PROD_W - FRAC_W;
    localparam int CUB_PROD_W    = X3_W + COEF_W + 1;
    localparam int LIN_TERM_W    = PROD_W - FRAC_W;
    localparam int CUB_TERM_W    = CUB_PROD_W - FRAC_W;
    localparam int VOL_Q_W       = PROD_W - GAIN_FRAC_W;
    localparam int RAW_W         = CUB_TERM_W + 1;
    localparam int FOLD_W        = RAW_W + 1;

    localparam logic [KIND_W-1:0] MODE_HALF   = 2'd0;
    localparam logic [KIND_W-1:0] MODE_SOFT   = 2'd1;
    localparam logic [KIND_W-1:0] MODE_FOLD   = 2'd2;
    localparam logic [KIND_W-1:0] MODE_VOLUME = 2'd3;

    localparam logic [CFG_ADDR_W-1:0] REG_THRESHOLD = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_LINEAR    = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_CUBIC     = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_VOLUME    = 2'd3;

    localparam logic [THRESH_W-1:0] THRESHOLD_RESET = 15'd22938;
    localparam logic [COEF_W-1:0]   LINEAR_RESET    = 16'd24567;
    localparam logic [COEF_W-1:0]   CUBIC_RESET     = 16'd16384;
    localparam logic [COEF_W-1:0]   VOLUME_RESET    = 16'd4096;

    localparam logic signed [FOLD_W-1:0] SAMPLE_MAX = 25'sd32767;
    localparam logic signed [FOLD_W-1:0] SAMPLE_MIN = -25'sd32768;
    localparam logic signed [FOLD_W-1:0] FOLD_HI    = 25'sd65534;
    localparam logic signed [FOLD_W-1:0] FOLD_LO    = -25'sd65536;

    typedef struct packed {
        logic [KIND_W-1:0]         kind;
        logic signed [SAMPLE_W-1:0] half_sum;
        logic signed [SUM_W-1:0]    sum;
        logic                       pass;
        logic signed [PROD_W-1:0]   sq;
        logic signed [PROD_W-1:0]   lin_prod;
        logic signed [PROD_W-1:0]   vol_prod;
    } front_t;

    typedef struct packed {
        logic [KIND_W-1:0]             kind;
        logic signed [SAMPLE_W-1:0]    half_sum;
        logic signed [SUM_W-1:0]       sum;
        logic                          pass;
        logic signed [LIN_TERM_W-1:0]  lin_term;
        logic signed [VOL_Q_W-1:0]     vol_q;
        logic signed [CUBE_PROD_W-1:0] cube_prod;
    } mid_t;

    typedef struct packed {
        logic [KIND_W-1:0]            kind;
        logic signed [SAMPLE_W-1:0]   half_sum;
        logic signed [SUM_W-1:0]      sum;
        logic                         pass;
        logic signed [LIN_TERM_W-1:0] lin_term;
        logic signed [VOL_Q_W-1:0]    vol_q;
        logic signed [CUB_PROD_W-1:0] cub_prod;
    } cube_t;

endpackage

// File: rtl/core/pcmmix_front.sv
// First pipeline stage: mixed sum, halved mix, square, linear and volume products.
module pcmmix_front
    import pcmmix_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [KIND_W-1:0]          kind,
    input  logic signed [SAMPLE_W-1:0] sample_a,
    input  logic signed [SAMPLE_W-1:0] sample_b,
    input  logic [THRESH_W-1:0]        shape_threshold,
    input  logic [COEF_W-1:0]          linear_coefficient,
    input  logic [COEF_W-1:0]          volume_gain,
    output logic                       out_valid,
    input  logic                       out_ready,
    output front_t                     out_data
);

    logic   valid_reg;
    front_t data_reg;
    front_t data_next;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb
    begin
        logic signed [SUM_W-1:0]  a_ext;
        logic signed [SUM_W-1:0]  b_ext;
        logic signed [SUM_W-1:0]  a_adj;
        logic signed [SUM_W-1:0]  b_adj;
        logic signed [SUM_W-1:0]  sum;
        logic signed [SUM_W-1:0]  thr;
        logic signed [PROD_W-1:0] sum_w;
        logic signed [PROD_W-1:0] lin_w;
        logic signed [PROD_W-1:0] a_w;
        logic signed [PROD_W-1:0] gain_w;
        logic signed [SAMPLE_W-1:0] a_half;
        logic signed [SAMPLE_W-1:0] b_half;

        a_ext = SUM_W'(sample_a);
        b_ext = SUM_W'(sample_b);
        sum   = a_ext + b_ext;
        // Halving toward zero: bias negative values by one before the floor shift.
        a_adj  = a_ext + $signed({{SAMPLE_W{1'b0}}, sample_a[SAMPLE_W-1]});
        b_adj  = b_ext + $signed({{SAMPLE_W{1'b0}}, sample_b[SAMPLE_W-1]});
        a_half = a_adj[SUM_W-1:1];
        b_half = b_adj[SUM_W-1:1];

        sum_w  = PROD_W'(sum);
        lin_w  = $signed({{(PROD_W-COEF_W){1'b0}}, linear_coefficient});
        a_w    = PROD_W'(sample_a);
        gain_w = $signed({{(PROD_W-COEF_W){1'b0}}, volume_gain});
        thr    = $signed({{(SUM_W-THRESH_W){1'b0}}, shape_threshold});

        data_next.kind     = kind;
        data_next.half_sum = a_half + b_half;
        data_next.sum      = sum;
        data_next.pass     = (sum <= thr) && (sum >= -thr);
        data_next.sq       = sum_w * sum_w;
        data_next.lin_prod = lin_w * sum_w;
        data_next.vol_prod = a_w * gain_w;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

endmodule

// File: rtl/core/pcmmix_cube.sv
// Second and third pipeline stages: cube of the sum and the cubic-term product.
module pcmmix_cube
    import pcmmix_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  front_t            in_data,
    input  logic [COEF_W-1:0] cubic_coefficient,
    output logic              out_valid,
    input  logic              out_ready,
    output cube_t             out_data
);

    logic  mid_valid_reg;
    mid_t  mid_reg;
    mid_t  mid_next;
    logic  mid_ready;
    logic  cube_valid_reg;
    cube_t cube_reg;
    cube_t cube_next;

    assign mid_ready = !cube_valid_reg || out_ready;
    assign in_ready  = !mid_valid_reg || mid_ready;
    assign out_valid = cube_valid_reg;
    assign out_data  = cube_reg;

    always_comb
    begin
        logic [X2_W-1:0]               x2;
        logic signed [CUBE_PROD_W-1:0] x2_w;
        logic signed [CUBE_PROD_W-1:0] sum_w;
        logic signed [PROD_W-1:0]      vol_adj;

        // The square is non-negative, so the floor shift is a plain bit slice.
        x2    = in_data.sq[PROD_W-2:FRAC_W];
        x2_w  = $signed({{(CUBE_PROD_W-X2_W){1'b0}}, x2});
        sum_w = CUBE_PROD_W'(in_data.sum);

        // Volume divide truncates toward zero: bias negative products first.
        if (in_data.vol_prod < 0)
        begin
            vol_adj = in_data.vol_prod + PROD_W'((1 << GAIN_FRAC_W) - 1);
        end
        else
        begin
            vol_adj = in_data.vol_prod;
        end

        mid_next.kind      = in_data.kind;
        mid_next.half_sum  = in_data.half_sum;
        mid_next.sum       = in_data.sum;
        mid_next.pass      = in_data.pass;
        mid_next.lin_term  = in_data.lin_prod[PROD_W-1:FRAC_W];
        mid_next.vol_q     = vol_adj[PROD_W-1:GAIN_FRAC_W];
        mid_next.cube_prod = x2_w * sum_w;
    end

    always_comb
    begin
        logic signed [X3_W-1:0]       x3;
        logic signed [CUB_PROD_W-1:0] x3_w;
        logic signed [CUB_PROD_W-1:0] cub_w;

        x3    = mid_reg.cube_prod[CUBE_PROD_W-1:FRAC_W];
        x3_w  = CUB_PROD_W'(x3);
        cub_w = $signed({{(CUB_PROD_W-COEF_W){1'b0}}, cubic_coefficient});

        cube_next.kind     = mid_reg.kind;
        cube_next.half_sum = mid_reg.half_sum;
        cube_next.sum      = mid_reg.sum;
        cube_next.pass     = mid_reg.pass;
        cube_next.lin_term = mid_reg.lin_term;
        cube_next.vol_q    = mid_reg.vol_q;
        cube_next.cub_prod = x3_w * cub_w;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mid_valid_reg  <= 1'b0;
            cube_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                mid_valid_reg <= in_valid;
            end
            if (mid_ready)
            begin
                cube_valid_reg <= mid_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            mid_reg <= mid_next;
        end
        if (mid_ready && mid_valid_reg)
        begin
            cube_reg <= cube_next;
        end
    end

endmodule

// File: rtl/core/pcmmix_limit.sv
// Final pipeline stage: mode select, single fold, saturation and output register.
module pcmmix_limit
    import pcmmix_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  cube_t                      in_data,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic signed [SAMPLE_W-1:0] mixed_sample,
    output logic                       was_limited
);

    logic                       valid_reg;
    logic signed [SAMPLE_W-1:0] sample_reg;
    logic signed [SAMPLE_W-1:0] sample_next;
    logic                       limited_reg;
    logic                       limited_next;

    assign in_ready     = !valid_reg || out_ready;
    assign out_valid    = valid_reg;
    assign mixed_sample = sample_reg;
    assign was_limited  = limited_reg;

    always_comb
    begin
        logic signed [CUB_TERM_W-1:0] cub_term;
        logic signed [RAW_W-1:0]      shaped;
        logic signed [RAW_W-1:0]      raw;
        logic signed [FOLD_W-1:0]     raw_w;
        logic signed [FOLD_W-1:0]     folded;
        logic signed [FOLD_W-1:0]     sat;

        cub_term = in_data.cub_prod[CUB_PROD_W-1:FRAC_W];
        shaped   = RAW_W'(in_data.lin_term) - RAW_W'(cub_term);

        unique case (in_data.kind)
            MODE_HALF:   raw = RAW_W'(in_data.half_sum);
            MODE_SOFT:   raw = in_data.pass ? RAW_W'(in_data.sum) : shaped;
            MODE_FOLD:   raw = RAW_W'(in_data.sum);
            MODE_VOLUME: raw = RAW_W'(in_data.vol_q);
            default:     raw = RAW_W'(in_data.sum);
        endcase

        raw_w  = FOLD_W'(raw);
        folded = raw_w;
        // Only the two summing modes reflect an overshoot back into range, once.
        if (in_data.kind == MODE_SOFT || in_data.kind == MODE_FOLD)
        begin
            priority if (raw_w > SAMPLE_MAX)
            begin
                folded = FOLD_HI - raw_w;
            end
            else if (raw_w < SAMPLE_MIN)
            begin
                folded = FOLD_LO - raw_w;
            end
            else
            begin
                folded = raw_w;
            end
        end

        priority if (folded > SAMPLE_MAX)
        begin
            sat = SAMPLE_MAX;
        end
        else if (folded < SAMPLE_MIN)
        begin
            sat = SAMPLE_MIN;
        end
        else
        begin
            sat = folded;
        end

        sample_next  = sat[SAMPLE_W-1:0];
        limited_next = (sat != raw_w);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            sample_reg  <= sample_next;
            limited_reg <= limited_next;
        end
    end

endmodule

// File: rtl/core/pcm16_mixer_soft_clip.sv
// Top level of the PCM16 two-input mixer with cubic soft clip, fold and volume modes.
//
// Usage: each slave-side transaction carries one sample pair and a mode in tuser.
// Mode 0 averages the samples, mode 1 adds them and passes the sum through a
// cubic Q15 waveshaper, mode 2 adds them, and mode 3 scales sample A by a Q4.12
// gain. Summing modes fold an overshoot back once, then every result saturates.
// Each input transaction yields exactly one master-side transaction, in order.
// A transaction accepted into the front register passes the mid, cube and
// output registers in turn before it is presented on the master side.
// Throughput is one transaction per cycle while the master side is not stalled,
// through four register stages (front products, square times sum, cubic
// coefficient product, fold and saturate), each at most one multiplier deep.
// Every stage has its own valid bit and moves when its successor has room, so
// a stall at the master side fills empty stages first and only then drops
// s_axis_tready; nothing is lost or repeated. Reset empties the pipeline and
// loads the four configuration registers with their default values.
// Configuration is written through cfg_we/cfg_addr/cfg_wdata and should only
// change while no transaction is in flight.
module pcm16_mixer_soft_clip
    import pcmmix_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [31:0]           s_axis_tdata,   // [15:0] sample_a, [31:16] sample_b
    input  logic [KIND_W-1:0]     s_axis_tuser,   // [1:0] kind
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [SAMPLE_W-1:0]   m_axis_tdata,   // [15:0] mixed_sample
    output logic                  m_axis_tuser,   // [0] was_limited
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [COEF_W-1:0]     cfg_wdata
);

    logic [THRESH_W-1:0] threshold_reg;
    logic [COEF_W-1:0]   linear_reg;
    logic [COEF_W-1:0]   cubic_reg;
    logic [COEF_W-1:0]   volume_reg;

    logic   front_valid;
    logic   front_ready;
    front_t front_data;
    logic   cube_valid;
    logic   cube_ready;
    cube_t  cube_data;

    logic signed [SAMPLE_W-1:0] mixed_sample;

    // Configuration registers. Every index of the two-bit address names a register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= THRESHOLD_RESET;
            linear_reg    <= LINEAR_RESET;
            cubic_reg     <= CUBIC_RESET;
            volume_reg    <= VOLUME_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_THRESHOLD: threshold_reg <= cfg_wdata[THRESH_W-1:0];
                REG_LINEAR:    linear_reg    <= cfg_wdata;
                REG_CUBIC:     cubic_reg     <= cfg_wdata;
                REG_VOLUME:    volume_reg    <= cfg_wdata;
                default:       volume_reg    <= volume_reg;
            endcase
        end
    end

    pcmmix_front u_front
    (
        .clk                (clk),
        .rst_n              (rst_n),
        .in_valid           (s_axis_tvalid),
        .in_ready           (s_axis_tready),
        .kind               (s_axis_tuser),
        .sample_a           ($signed(s_axis_tdata[SAMPLE_W-1:0])),
        .sample_b           ($signed(s_axis_tdata[2*SAMPLE_W-1:SAMPLE_W])),
        .shape_threshold    (threshold_reg),
        .linear_coefficient (linear_reg),
        .volume_gain        (volume_reg),
        .out_valid          (front_valid),
        .out_ready          (front_ready),
        .out_data           (front_data)
    );

    pcmmix_cube u_cube
    (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (front_valid),
        .in_ready          (front_ready),
        .in_data           (front_data),
        .cubic_coefficient (cubic_reg),
        .out_valid         (cube_valid),
        .out_ready         (cube_ready),
        .out_data          (cube_data)
    );

    pcmmix_limit u_limit
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (cube_valid),
        .in_ready     (cube_ready),
        .in_data      (cube_data),
        .out_valid    (m_axis_tvalid),
        .out_ready    (m_axis_tready),
        .mixed_sample (mixed_sample),
        .was_limited  (m_axis_tuser)
    );

    assign m_axis_tdata = mixed_sample;

`ifndef SYNTHESIS
    // Input back-pressure only appears once every stage is full and the output is stalled.
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
        else $error("input stalled while the pipeline still has room");

    // A halved mix can never overflow, so it must leave the pipeline unflagged.
    assert property (@(posedge clk) disable iff (!rst_n)
        (cube_valid && cube_ready && cube_data.kind == MODE_HALF) |=> !m_axis_tuser)
        else $error("halved mix reported as limited");

    // A front-stage transaction blocked by the cube stage must still be present next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (front_valid && !front_ready) |=> front_valid)
        else $error("front stage dropped a stalled transaction");
`endif

endmodule

// File: tb/sv/tb.sv
// Self-checking testbench for the PCM16 mixer with soft clip, fold and volume modes.
`timescale 1ns / 1ps

module tb;
    import pcmmix_pkg::*;

    // Clock, reset and run limits. The drain waits for every owed result, so a
    // short pause after the last result is enough.
    localparam int RESET_CYCLES = 11;
    localparam int SETTLE_CYCLES = 12;
    localparam int STALL_LIMIT = 2000;
    localparam int HOLD_CYCLES = 64;
    localparam int REPORT_CAP = 100;

    // Register values after reset, as the block is specified.
    localparam longint DEF_THRESHOLD = 22938;
    localparam longint DEF_LINEAR = 24567;
    localparam longint DEF_CUBIC = 16384;
    localparam longint DEF_VOLUME = 4096;

    // Signed sample range used by the fold and the clamp.
    localparam longint PCM_MAX = (longint'(1) << (SAMPLE_W - 1)) - 1;
    localparam longint PCM_MIN = -(longint'(1) << (SAMPLE_W - 1));

    // One transaction as it should leave the block, with the input that caused it
    // kept for the error message.
    typedef struct {
        logic [KIND_W-1:0]          kind;
        logic signed [SAMPLE_W-1:0] a;
        logic signed [SAMPLE_W-1:0] b;
        logic [SAMPLE_W-1:0]        sample;
        logic                       limited;
    } mix_expect_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [31:0]           s_axis_tdata = '0;     // [15:0] sample_a, [31:16] sample_b
    logic [KIND_W-1:0]     s_axis_tuser = '0;     // [1:0] kind
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [SAMPLE_W-1:0]   m_axis_tdata;          // [15:0] mixed_sample
    logic                  m_axis_tuser;          // [0] was_limited
    logic                  cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [COEF_W-1:0]     cfg_wdata = '0;

    // The testbench copy of the four configuration registers.
    longint shape_thr = DEF_THRESHOLD;
    longint lin_coef = DEF_LINEAR;
    longint cub_coef = DEF_CUBIC;
    longint vol_gain = DEF_VOLUME;

    // Results still owed by the block, oldest first.
    mix_expect_t expected_mixes[$];

    int mismatch_count = 0;
    int quiet_cycles = 0;
    int src_idle_pct = 0;
    int sink_idle_pct = 0;
    int hold_asks = 0;
    int hold_seen = 0;
    int hold_left = 0;

    pcm16_mixer_soft_clip dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 0;
    end

    // Works out the result of one sample pair under the current register values.
    // All arithmetic is done in 64 bits, which holds the largest cube product
    // with room to spare. The >>> operator on a signed operand is a floor shift,
    // and signed division truncates toward zero, as the modes require.
    function automatic mix_expect_t predict_mix(input logic [KIND_W-1:0] kind,
                                                input logic signed [SAMPLE_W-1:0] a,
                                                input logic signed [SAMPLE_W-1:0] b);
        mix_expect_t r;
        longint sa;
        longint sb;
        longint sum;
        longint sq;
        longint cube;
        longint raw;
        longint y;
        sa = a;
        sb = b;
        sum = sa + sb;
        case (kind)
            MODE_HALF: raw = sa / 2 + sb / 2;
            MODE_SOFT:
            begin
                if (sum <= shape_thr && sum >= -shape_thr)
                    raw = sum;
                else
                begin
                    sq = (sum * sum) >>> FRAC_W;
                    cube = (sq * sum) >>> FRAC_W;
                    raw = ((lin_coef * sum) >>> FRAC_W) - ((cub_coef * cube) >>> FRAC_W);
                end
            end
            MODE_FOLD: raw = sum;
            default: raw = (sa * vol_gain) / (longint'(1) << GAIN_FRAC_W);
        endcase
        y = raw;
        // Only the summing modes fold, and only once; the clamp catches the rest.
        if (kind == MODE_SOFT || kind == MODE_FOLD)
        begin
            if (y > PCM_MAX)
                y = 2 * PCM_MAX - y;
            else if (y < PCM_MIN)
                y = 2 * PCM_MIN - y;
        end
        if (y > PCM_MAX)
            y = PCM_MAX;
        else if (y < PCM_MIN)
            y = PCM_MIN;
        r.kind = kind;
        r.a = a;
        r.b = b;
        r.sample = y[SAMPLE_W-1:0];
        r.limited = (y != raw);
        return r;
    endfunction

    // Random sample: half of them over the whole range, the rest crowded near
    // the two rails and near zero, where rounding and overflow live.
    function automatic logic signed [SAMPLE_W-1:0] rand_sample();
        int pick;
        pick = $urandom_range(9);
        if (pick < 5)
            return SAMPLE_W'($urandom);
        if (pick < 6)
            return 16'h7FFF - SAMPLE_W'($urandom_range(15));
        if (pick < 7)
            return 16'h8000 + SAMPLE_W'($urandom_range(15));
        return SAMPLE_W'($urandom_range(600)) - 16'd300;
    endfunction

    task automatic report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= REPORT_CAP)
            $display("[%0t] mismatch: %s", $time, what);
    endtask

    // Writes all four registers on consecutive cycles. Only called while the
    // pipeline is empty, so no transaction in flight sees a mix of settings.
    task automatic load_settings(input logic [COEF_W-1:0] thr, input logic [COEF_W-1:0] lin,
                                 input logic [COEF_W-1:0] cub, input logic [COEF_W-1:0] vol);
        cfg_we <= 1'b1;
        cfg_addr <= REG_THRESHOLD;
        cfg_wdata <= thr;
        @(posedge clk);
        cfg_addr <= REG_LINEAR;
        cfg_wdata <= lin;
        @(posedge clk);
        cfg_addr <= REG_CUBIC;
        cfg_wdata <= cub;
        @(posedge clk);
        cfg_addr <= REG_VOLUME;
        cfg_wdata <= vol;
        @(posedge clk);
        cfg_we <= 1'b0;
        // The threshold register is one bit narrower; the top bit of the write is dropped.
        shape_thr = longint'(thr[THRESH_W-1:0]);
        lin_coef = longint'(lin);
        cub_coef = longint'(cub);
        vol_gain = longint'(vol);
    endtask

    // Offers one sample pair and returns at the clock edge where the transaction
    // is accepted. The valid stays high on return so back-to-back items leave no
    // bubble; the sender's idle percentage decides whether a gap comes first.
    task automatic send_pair(input logic [KIND_W-1:0] kind, input logic signed [SAMPLE_W-1:0] a,
                             input logic signed [SAMPLE_W-1:0] b);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {b, a};
        s_axis_tuser <= kind;
        expected_mixes.push_back(predict_mix(kind, a, b));
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    task automatic send_random_item();
        logic [KIND_W-1:0]          kind;
        logic signed [SAMPLE_W-1:0] a;
        logic signed [SAMPLE_W-1:0] b;
        longint                     s;
        int                         d;
        kind = KIND_W'($urandom_range(3));
        a = rand_sample();
        b = rand_sample();
        if (kind == MODE_SOFT && $urandom_range(3) == 0)
        begin
            // Put the sum within two steps of the edge of the pass band and split
            // it unevenly between the two samples.
            d = $urandom_range(4);
            s = ($urandom_range(1) ? shape_thr : -shape_thr) + d - 2;
            d = $urandom_range(8000);
            a = SAMPLE_W'(s / 2 + d);
            b = SAMPLE_W'(s - (s / 2 + d));
        end
        send_pair(kind, a, b);
    endtask

    // Stops offering and waits until every owed result is back, then lets the
    // pipeline settle so a register write cannot catch anything in flight.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (expected_mixes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic run_setting(input logic [COEF_W-1:0] thr, input logic [COEF_W-1:0] lin,
                               input logic [COEF_W-1:0] cub, input logic [COEF_W-1:0] vol,
                               input int count);
        load_settings(thr, lin, cub, vol);
        repeat (count) send_random_item();
        drain();
    endtask

    // Hand-picked pairs under the reset register values: both rails, odd values
    // whose halves truncate toward zero, sums exactly on and just past the pass
    // band of the waveshaper, overflow in both directions for the fold, and the
    // volume mode at unity gain with sample B set to something it must ignore.
    task automatic test_directed_corners();
        src_idle_pct = 0;
        sink_idle_pct <= 0;
        send_pair(MODE_HALF, 16'sh7FFF, 16'sh7FFF);
        send_pair(MODE_HALF, -16'sh8000, -16'sh8000);
        send_pair(MODE_HALF, -16'sd1, -16'sd1);
        send_pair(MODE_HALF, 16'sd3, -16'sd1);
        send_pair(MODE_HALF, -16'sd32767, -16'sd3);
        send_pair(MODE_SOFT, 16'sd0, 16'sd0);
        send_pair(MODE_SOFT, 16'sd22938, 16'sd0);
        send_pair(MODE_SOFT, -16'sd22938, 16'sd0);
        send_pair(MODE_SOFT, 16'sd22939, 16'sd0);
        send_pair(MODE_SOFT, -16'sd22939, 16'sd0);
        send_pair(MODE_SOFT, 16'sh7FFF, 16'sh7FFF);
        send_pair(MODE_SOFT, -16'sh8000, -16'sh8000);
        send_pair(MODE_SOFT, 16'sd20000, -16'sd1);
        send_pair(MODE_FOLD, 16'sh7FFF, 16'sh7FFF);
        send_pair(MODE_FOLD, -16'sh8000, -16'sh8000);
        send_pair(MODE_FOLD, 16'sh7FFF, 16'sd1);
        send_pair(MODE_FOLD, -16'sh8000, -16'sd1);
        send_pair(MODE_FOLD, 16'sd100, -16'sd200);
        send_pair(MODE_VOLUME, 16'sh7FFF, -16'sh8000);
        send_pair(MODE_VOLUME, -16'sh8000, 16'sh7FFF);
        send_pair(MODE_VOLUME, -16'sd1, 16'sd0);
        send_pair(MODE_VOLUME, 16'sd12345, -16'sd1);
        drain();
    endtask

    task automatic test_random_traffic(input int count, input int src_pct, input int sink_pct);
        src_idle_pct = src_pct;
        sink_idle_pct <= sink_pct;
        repeat (count) send_random_item();
        drain();
    endtask

    // Register extremes. A zero threshold sends every nonzero sum through the
    // cubic; a threshold written as all ones must act as the largest
    // 15-bit value. Large linear coefficients drive the shaper past the fold
    // range so the clamp has to act, and volume runs from mute to the top gain.
    task automatic test_register_sweep();
        src_idle_pct = 53;
        sink_idle_pct <= 13;
        run_setting(16'd0, 16'hFFFF, 16'd0, 16'hFFFF, 120);
        run_setting(16'hFFFF, 16'd0, 16'hFFFF, 16'd0, 120);
        run_setting(16'd0, 16'd32768, 16'hFFFF, 16'd1, 120);
        run_setting(16'd1, 16'd0, 16'd0, 16'd8192, 120);
        run_setting(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), 120);
    endtask

    // Full-rate traffic on both sides under a handful of random settings.
    task automatic test_random_settings();
        src_idle_pct = 0;
        sink_idle_pct <= 0;
        repeat (5)
            run_setting(16'($urandom), 16'($urandom), 16'($urandom),
                        16'($urandom_range(12000)), 130);
    endtask

    // The receiver refuses everything for a long stretch while the sender keeps
    // offering, so the pipeline fills and has to drop its input ready.
    task automatic test_output_backpressure();
        src_idle_pct = 0;
        sink_idle_pct <= 0;
        hold_asks <= hold_asks + 1;
        repeat (30) send_random_item();
        drain();
    endtask

    // Receiver: a hold-off request outranks the random idling.
    always @(posedge clk)
    begin
        if (hold_asks != hold_seen)
        begin
            hold_seen <= hold_asks;
            hold_left <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
    end

    // Result checker: the sample and limit flag of every accepted result are
    // matched against the oldest prediction.
    always @(posedge clk)
    begin : check_results
        mix_expect_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_mixes.size() == 0)
                report_mismatch($sformatf("result %h with nothing outstanding", m_axis_tdata));
            else
            begin
                want = expected_mixes.pop_front();
                if (m_axis_tdata !== want.sample)
                    report_mismatch($sformatf("kind %0d a %0d b %0d: mixed_sample %0d, want %0d",
                                              want.kind, want.a, want.b,
                                              $signed(m_axis_tdata), $signed(want.sample)));
                if (m_axis_tuser !== want.limited)
                    report_mismatch($sformatf("kind %0d a %0d b %0d: was_limited %b, want %b",
                                              want.kind, want.a, want.b,
                                              m_axis_tuser, want.limited));
            end
        end
    end

    // Watchdog: too many cycles in a row without any transaction on either
    // side means the block has hung.
    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("pcm16_mixer_soft_clip test failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        test_directed_corners();
        test_random_traffic(650, 13, 53);
        test_register_sweep();
        test_random_settings();
        test_output_backpressure();
        if (mismatch_count == 0)
            $display("pcm16_mixer_soft_clip test passed");
        else
            $display("pcm16_mixer_soft_clip test failed");
        $finish;
    end

endmodule

// File: pcm16_mixer_soft_clip.f
rtl/core/pcmmix_pkg.sv
rtl/core/pcmmix_front.sv
rtl/core/pcmmix_cube.sv
rtl/core/pcmmix_limit.sv
rtl/core/pcm16_mixer_soft_clip.sv
tb/sv/tb.sv
